### rtl/u32u8enc_pkg.sv
// Package with the shared types and constants of the UTF-32 to UTF-8 encoder.
package u32u8enc_pkg;

   localparam logic [31:0] MarkNative  = 32'h0000_FEFF;
   localparam logic [31:0] MarkSwapped = 32'hFFFE_0000;
   localparam logic [31:0] MaxOneByte   = 32'h0000_007F;
   localparam logic [31:0] MaxTwoByte   = 32'h0000_07FF;
   localparam logic [31:0] MaxThreeByte = 32'h0000_FFFF;
   localparam logic [31:0] MaxCodePoint = 32'h0010_FFFF;

   localparam logic [7:0] LeadTwo   = 8'hC0;
   localparam logic [7:0] LeadThree = 8'hE0;
   localparam logic [7:0] LeadFour  = 8'hF0;
   localparam logic [7:0] ContMark  = 8'h80;

   localparam logic StatusData     = 1'b0;
   localparam logic StatusBadMark  = 1'b1;

   localparam int DefaultQueueDepth = 2;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
      logic            status;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

### rtl/u32u8enc_ifs.sv
// Channel interfaces of the encoder: the word request and the byte response.
interface u32u8enc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] word;
   logic        start_of_stream;

   modport source (output valid, output word, output start_of_stream, input ready);
   modport sink (input valid, input word, input start_of_stream, output ready);
endinterface

interface u32u8enc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;
   logic       status;

   modport source (output valid, output out_byte, output last, output status, input ready);
   modport sink (input valid, input out_byte, input last, input status, output ready);
endinterface

### rtl/u32u8enc_front.sv
// Front end: takes request beats, tracks the byte-order mark and builds byte jobs.
module u32u8enc_front
   import u32u8enc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [31:0]      req_word,
   input  logic             req_start_of_stream,
   input  queue_status_type q_status,
   output push_type         push
);

   logic        swap_ff, swap_in;
   logic        failed_ff, failed_in;
   logic        accept;
   logic [31:0] cp;
   job_type     job;
   logic        emit;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   assign cp = swap_ff ? {req_word[7:0], req_word[15:8], req_word[23:16], req_word[31:24]}
                       : req_word;

   always_comb begin
      job  = '0;
      emit = 1'b0;
      if (req_start_of_stream) begin
         job.status = StatusBadMark;
         emit = (req_word != MarkNative) && (req_word != MarkSwapped);
      end else if (!failed_ff) begin
         job.status = StatusData;
         if (cp <= MaxOneByte) begin
            job.bytes[0] = {1'b0, cp[6:0]};
            job.last_idx = 2'd0;
            emit = 1'b1;
         end else if (cp <= MaxTwoByte) begin
            job.bytes[0] = LeadTwo | {3'b000, cp[10:6]};
            job.bytes[1] = ContMark | {2'b00, cp[5:0]};
            job.last_idx = 2'd1;
            emit = 1'b1;
         end else if (cp <= MaxThreeByte) begin
            job.bytes[0] = LeadThree | {4'b0000, cp[15:12]};
            job.bytes[1] = ContMark | {2'b00, cp[11:6]};
            job.bytes[2] = ContMark | {2'b00, cp[5:0]};
            job.last_idx = 2'd2;
            emit = 1'b1;
         end else if (cp <= MaxCodePoint) begin
            job.bytes[0] = LeadFour | {5'b00000, cp[20:18]};
            job.bytes[1] = ContMark | {2'b00, cp[17:12]};
            job.bytes[2] = ContMark | {2'b00, cp[11:6]};
            job.bytes[3] = ContMark | {2'b00, cp[5:0]};
            job.last_idx = 2'd3;
            emit = 1'b1;
         end
      end
   end

   assign push.valid = accept && emit;
   assign push.job   = job;

   always_comb begin
      swap_in   = swap_ff;
      failed_in = failed_ff;
      if (accept && req_start_of_stream) begin
         swap_in   = (req_word == MarkSwapped);
         failed_in = (req_word != MarkNative) && (req_word != MarkSwapped);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         swap_ff   <= 1'b0;
         failed_ff <= 1'b1;
      end else begin
         swap_ff   <= swap_in;
         failed_ff <= failed_in;
      end
   end

endmodule

### rtl/u32u8enc_queue.sv
// Small job queue between the front end and the byte sequencer.
module u32u8enc_queue
   import u32u8enc_pkg::*;
#(
   parameter int QueueDepth = DefaultQueueDepth
)
(
   input  logic             clock,
   input  logic             reset,
   input  push_type         push,
   input  logic             pop,
   output job_type          head,
   output queue_status_type q_status
);

   localparam int PtrWidth = $clog2(QueueDepth);
   localparam int CntWidth = $clog2(QueueDepth + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(QueueDepth - 1);
   localparam logic [CntWidth-1:0] FullCnt = CntWidth'(QueueDepth);

   job_type               mem_ff [QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign q_status.full  = (count_ff == FullCnt);
   assign q_status.empty = (count_ff == '0);
   assign do_push = push.valid && !q_status.full;
   assign do_pop  = pop && !q_status.empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/u32u8enc_back.sv
// Back end: steps through a job one byte per beat into the response register.
module u32u8enc_back
   import u32u8enc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  job_type          head,
   input  queue_status_type q_status,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last,
   output logic             rsp_status
);

   logic       cur_valid_ff, cur_valid_in;
   job_type    cur_job_ff, cur_job_in;
   logic [1:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_last_ff, out_last_in;
   logic       out_status_ff, out_status_in;
   logic       out_load, is_last, cur_free;

   assign out_load = cur_valid_ff && (!out_valid_ff || rsp_ready);
   assign is_last  = (idx_ff == cur_job_ff.last_idx);
   assign cur_free = !cur_valid_ff || (out_load && is_last);
   assign pop      = cur_free && !q_status.empty;

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_job_in   = cur_job_ff;
      idx_in       = idx_ff;
      if (out_load) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cur_free) begin
         cur_valid_in = pop;
         cur_job_in   = head;
         idx_in       = '0;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;
      out_status_in = out_status_ff;
      if (out_load) begin
         out_valid_in  = 1'b1;
         out_byte_in   = cur_job_ff.bytes[idx_ff];
         out_last_in   = is_last;
         out_status_in = cur_job_ff.status;
      end
   end

   always_ff @(posedge clock) begin
      cur_job_ff    <= cur_job_in;
      out_byte_ff   <= out_byte_in;
      out_last_ff   <= out_last_in;
      out_status_ff <= out_status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_last     = out_last_ff;
   assign rsp_status   = out_status_ff;

endmodule

### rtl/utf32_to_utf8_encoder_top.sv
// Top level of the UTF-32 to UTF-8 encoder: front end, job queue and byte sequencer.
//
//   Channel  Direction  Payload                        Beat
//   req      in         word[31:0], start_of_stream    one UTF-32 word
//   rsp      out        out_byte[7:0], last, status    one UTF-8 byte or a mark error
//
// A word in range yields one to four response beats, one per cycle while rsp is ready;
// a bad mark yields a single mark-error beat, and a valid mark or a dropped word
// yields none. Reset is synchronous; after it no stream is open until a valid
// mark arrives. The queue lets the request side run on while the response is stalled.
module utf32_to_utf8_encoder_top
   import u32u8enc_pkg::*;
#(
   parameter int QueueDepth = DefaultQueueDepth
)
(
   input logic            clock,
   input logic            reset,
   u32u8enc_req_if.sink   req,
   u32u8enc_rsp_if.source rsp
);

   push_type         push;
   logic             pop;
   job_type          head;
   queue_status_type q_status;

   u32u8enc_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req.valid),
      .req_ready           (req.ready),
      .req_word            (req.word),
      .req_start_of_stream (req.start_of_stream),
      .q_status            (q_status),
      .push                (push)
   );

   u32u8enc_queue #(
      .QueueDepth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .pop      (pop),
      .head     (head),
      .q_status (q_status)
   );

   u32u8enc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .q_status     (q_status),
      .pop          (pop),
      .rsp_valid    (rsp.valid),
      .rsp_ready    (rsp.ready),
      .rsp_out_byte (rsp.out_byte),
      .rsp_last     (rsp.last),
      .rsp_status   (rsp.status)
   );

   // A valid byte-order mark never places a job in the queue.
   assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.start_of_stream &&
       (req.word == MarkNative || req.word == MarkSwapped)) |-> !push.valid)
      else $error("byte-order mark produced a job");

   assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue reports full and empty together");

   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == StatusBadMark) |-> (rsp.last && rsp.out_byte == '0))
      else $error("mark error beat is malformed");

   // Every byte of a multi-byte sequence other than the final one has its top bit set.
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == StatusData && !rsp.last) |-> rsp.out_byte[7])
      else $error("leading byte without continuation marker");

endmodule

### tb/utf32_to_utf8_encoder_checker.sv
`timescale 1ns / 100ps
// Checker of the encoder: watches both channels, predicts the UTF-8 bytes and compares them.
module utf32_to_utf8_encoder_checker
   import u32u8enc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_word,
   input  logic        req_start_of_stream,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_last,
   input  logic        rsp_status,
   output int          mismatch_count,
   output int          bytes_outstanding
);

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic       status;
   } utf8_beat_type;

   utf8_beat_type expected_bytes[$];
   logic          stream_swapped = 1'b0;
   logic          stream_broken  = 1'b1;
   int            mismatch_total = 0;
   int            queued_total   = 0;

   assign mismatch_count    = mismatch_total;
   assign bytes_outstanding = queued_total;

   task automatic report_mismatch(input string what, input utf8_beat_type got,
                                  input utf8_beat_type wanted);
      $display("%0t: %s: got byte %h last %b status %b, wanted byte %h last %b status %b",
               $realtime, what, got.out_byte, got.last, got.status,
               wanted.out_byte, wanted.last, wanted.status);
      mismatch_total++;
   endtask

   function automatic void push_byte(input logic [7:0] value, input logic is_last,
                                     input logic status);
      utf8_beat_type beat;
      beat.out_byte = value;
      beat.last     = is_last;
      beat.status   = status;
      expected_bytes.push_back(beat);
   endfunction

   function automatic logic [31:0] swap_order(input logic [31:0] value);
      return {value[7:0], value[15:8], value[23:16], value[31:24]};
   endfunction

   function automatic void encode_word(input logic [31:0] raw, input logic starts_stream);
      logic [31:0] cp;
      if (starts_stream) begin
         if (raw == MarkNative || raw == MarkSwapped) begin
            stream_swapped = (raw == MarkSwapped);
            stream_broken  = 1'b0;
         end else begin
            stream_swapped = 1'b0;
            stream_broken  = 1'b1;
            push_byte(8'h00, 1'b1, StatusBadMark);
         end
         return;
      end
      if (stream_broken) return;
      cp = stream_swapped ? swap_order(raw) : raw;
      if (cp <= MaxOneByte) begin
         push_byte(cp[7:0], 1'b1, StatusData);
      end else if (cp <= MaxTwoByte) begin
         push_byte(LeadTwo | {3'b000, cp[10:6]}, 1'b0, StatusData);
         push_byte(ContMark | {2'b00, cp[5:0]}, 1'b1, StatusData);
      end else if (cp <= MaxThreeByte) begin
         push_byte(LeadThree | {4'b0000, cp[15:12]}, 1'b0, StatusData);
         push_byte(ContMark | {2'b00, cp[11:6]}, 1'b0, StatusData);
         push_byte(ContMark | {2'b00, cp[5:0]}, 1'b1, StatusData);
      end else if (cp <= MaxCodePoint) begin
         push_byte(LeadFour | {5'b00000, cp[20:18]}, 1'b0, StatusData);
         push_byte(ContMark | {2'b00, cp[17:12]}, 1'b0, StatusData);
         push_byte(ContMark | {2'b00, cp[11:6]}, 1'b0, StatusData);
         push_byte(ContMark | {2'b00, cp[5:0]}, 1'b1, StatusData);
      end
   endfunction

   always @(posedge clock) begin
      utf8_beat_type seen;
      utf8_beat_type wanted;
      if (reset) begin
         stream_swapped = 1'b0;
         stream_broken  = 1'b1;
         expected_bytes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen.out_byte = rsp_out_byte;
            seen.last     = rsp_last;
            seen.status   = rsp_status;
            if (expected_bytes.size() == 0) begin
               report_mismatch("unexpected response beat", seen, '0);
            end else begin
               wanted = expected_bytes.pop_front();
               if (seen !== wanted) report_mismatch("wrong response beat", seen, wanted);
            end
         end
         if (req_valid && req_ready) encode_word(req_word, req_start_of_stream);
      end
      queued_total = expected_bytes.size();
   end

endmodule

### tb/utf32_to_utf8_encoder_top_tb.sv
`timescale 1ns / 100ps
// Testbench top of the encoder: clock, reset, word stimulus, response pacing and verdict.
module utf32_to_utf8_encoder_top_tb;
   import u32u8enc_pkg::*;

   localparam int CycleLimit  = 200000;
   localparam int RandomWords = 245;

   logic clock = 1'b0;
   logic reset;
   int   send_idle_pct     = 0;
   int   recv_stall_pct    = 0;
   int   cycle_count       = 0;
   int   mismatch_count;
   int   bytes_outstanding;

   u32u8enc_req_if req_ch();
   u32u8enc_rsp_if rsp_ch();

   utf32_to_utf8_encoder_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   utf32_to_utf8_encoder_checker checker_inst (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_ch.valid),
      .req_ready           (req_ch.ready),
      .req_word            (req_ch.word),
      .req_start_of_stream (req_ch.start_of_stream),
      .rsp_valid           (rsp_ch.valid),
      .rsp_ready           (rsp_ch.ready),
      .rsp_out_byte        (rsp_ch.out_byte),
      .rsp_last            (rsp_ch.last),
      .rsp_status          (rsp_ch.status),
      .mismatch_count      (mismatch_count),
      .bytes_outstanding   (bytes_outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      cycle_count  <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic logic [31:0] swap_order(input logic [31:0] value);
      return {value[7:0], value[15:8], value[23:16], value[31:24]};
   endfunction

   task automatic send_word(input logic [31:0] word, input logic starts_stream);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.word            <= word;
      req_ch.start_of_stream <= starts_stream;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // The sender holds off until every predicted byte has come back.
   task automatic pause_and_pace(input int idle_pct, input int stall_pct);
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (bytes_outstanding != 0);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      @(posedge clock);
   endtask

   function automatic logic [31:0] random_code_point();
      case ($urandom_range(0, 9))
         0, 1:    return $urandom_range(0, 32'h7F);
         2, 3:    return $urandom_range(32'h80, 32'h7FF);
         4, 5:    return $urandom_range(32'h800, 32'hFFFF);
         6, 7:    return $urandom_range(32'h1_0000, 32'h10_FFFF);
         8:       return $urandom_range(32'h11_0000, 32'hFFFF_FFFF);
         default: return $urandom();
      endcase
   endfunction

   initial begin
      int          words_counted;
      int          phase;
      int          stream_len;
      logic [31:0] mark;
      logic [31:0] cp;
      logic        swapped;

      reset                  <= 1'b1;
      req_ch.valid           <= 1'b0;
      req_ch.word            <= '0;
      req_ch.start_of_stream <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Words before any stream and after a bad mark are dropped.
      send_word(32'h0000_0041, 1'b0);
      send_word(32'h1234_5678, 1'b1);
      send_word(32'h0000_0041, 1'b0);
      send_word(MarkNative, 1'b1);
      send_word(32'h0000_0000, 1'b0);
      send_word(32'h0000_007F, 1'b0);
      send_word(32'h0000_0080, 1'b0);
      send_word(32'h0000_07FF, 1'b0);
      send_word(32'h0000_0800, 1'b0);
      send_word(32'h0000_D800, 1'b0);
      send_word(32'h0000_DFFF, 1'b0);
      send_word(32'h0000_FFFF, 1'b0);
      send_word(MarkNative, 1'b0);
      send_word(32'h0001_0000, 1'b0);
      send_word(32'h0010_FFFF, 1'b0);
      send_word(32'h0011_0000, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(MarkSwapped, 1'b1);
      send_word(swap_order(32'h0000_0041), 1'b0);
      send_word(swap_order(32'h0000_D800), 1'b0);
      send_word(swap_order(32'h0010_FFFF), 1'b0);
      send_word(swap_order(32'h0011_0000), 1'b0);
      send_word(32'h0000_00FF, 1'b0);
      send_word(32'h0000_0000, 1'b1);
      send_word(32'h0000_0041, 1'b0);
      pause_and_pace(0, 0);

      words_counted = 0;
      phase         = 0;
      while (words_counted < RandomWords) begin
         if (words_counted * 4 / RandomWords != phase) begin
            phase = words_counted * 4 / RandomWords;
            case (phase)
               1:       pause_and_pace(65, 0);
               2:       pause_and_pace(0, 65);
               default: pause_and_pace(35, 35);
            endcase
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3: mark = MarkNative;
            4, 5, 6, 7: mark = MarkSwapped;
            8:          mark = MarkNative ^ (32'h1 << $urandom_range(0, 31));
            default:    mark = $urandom();
         endcase
         swapped = (mark == MarkSwapped);
         send_word(mark, 1'b1);
         words_counted++;
         stream_len = $urandom_range(1, 10);
         repeat (stream_len) begin
            cp = random_code_point();
            send_word(swapped ? swap_order(cp) : cp, 1'b0);
            words_counted++;
         end
      end

      pause_and_pace(0, 0);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### utf32_to_utf8_encoder_top.f
rtl/u32u8enc_pkg.sv
rtl/u32u8enc_ifs.sv
rtl/u32u8enc_front.sv
rtl/u32u8enc_queue.sv
rtl/u32u8enc_back.sv
rtl/utf32_to_utf8_encoder_top.sv
tb/utf32_to_utf8_encoder_checker.sv
tb/utf32_to_utf8_encoder_top_tb.sv
